@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the labeler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define DSCL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// A condition that must hold in the clock after a trigger.
`define DSCL_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ hw/rtl/dscl_pkg.sv @@
// Types and constants shared by the downstream stream cell labeler.
package dscl_pkg;

    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = $clog2(MAX_COLS + 1);

    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int COLS_FIELD_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CODES_UW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODES_EL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 2'd2;

    localparam logic [CFG_W-1:0] CODES_UW_RST = 32'h1080_4020;
    localparam logic [CFG_W-1:0] CODES_EL_RST = 32'h0204_0801;
    localparam logic [CNT_W-1:0] COLS_RST     = CNT_W'((MAX_COLS < 1024) ? MAX_COLS : 1024);

    localparam int LABEL_W = 31;
    localparam logic [LABEL_W-1:0] LABEL_MAX = '1;
    localparam logic [LABEL_W-1:0] LABEL_RST = 31'd1;

    // Neighbor order is NW, N, NE, W, E, SW, S, SE (bit 0 is NW).
    localparam logic [7:0] LEFT_SIDE  = 8'b0010_1001;
    localparam logic [7:0] RIGHT_SIDE = 8'b1001_0100;

    typedef struct packed {
        logic               op;
        logic [7:0]         dir_code;
        logic               dir_present;
        logic signed [31:0] stream_id;
        logic               stream_present;
    } t_in;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               label_present;
    } t_out;

    // Compressed view of one cell as the line memory keeps it.
    typedef struct packed {
        logic       raster;
        logic       s_pres;
        logic       s_nz;
        logic       d_pres;
        logic [7:0] d_code;
    } t_cell;

    // One line memory word: the cell one row up and the nonzero bit two rows up.
    typedef struct packed {
        t_cell row1;
        logic  row2_nz;
    } t_word;

    typedef struct packed {
        t_cell      self_cell;
        logic [7:0] nb_nz;
        logic       at_left;
        logic       at_right;
    } t_window;

endpackage

@@ hw/rtl/downstream_stream_cell_labeler.sv @@
// Top level of the downstream stream cell labeler.
//
// Raster cells enter on the input channel (i_valid, o_stall, i_data) in row-major
// order, one word per clock when nothing stalls. Each accepted word yields the
// result for the cell one row and one column back: the cell at the center of a
// 3x3 window built from a line memory and a few tap registers. A result word
// goes through the window stage and queue to (o_valid, i_stall, o_data) after the
// input word that completes its window is accepted; words for positions before
// the raster start or for flush cells produce nothing. After the last row the
// user sends cols_in_use+1 flush words to push out the final results.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the direction
// code registers and the row width; writing the row width restarts the raster
// without touching the label counter.
// Throughput is one word per clock when nothing stalls, set by the single line
// memory: read at accept, written back the clock after. A three-word result queue
// sits in front of the output; o_stall rises only when the queue and the word in
// flight could fill it, so a stalled receiver does not stall the input at once.
// Reset is synchronous and active low: the line memory needs no clearing pass,
// since a row-fill flag masks its contents until a full row has been written, and
// o_stall is held high while reset is asserted.
`include "assert_macros.svh"

module downstream_stream_cell_labeler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  dscl_pkg::t_in                       i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output dscl_pkg::t_out                      o_data,
    input  logic                                i_cfg_we,
    input  logic [dscl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dscl_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int Q_DEPTH = 3;
    localparam int WORD_W  = $bits(dscl_pkg::t_word);

    // Configuration registers.
    logic [dscl_pkg::CFG_W-1:0] r_codes_uw;
    logic [dscl_pkg::CFG_W-1:0] r_codes_el;
    logic [dscl_pkg::CNT_W-1:0] r_cols;
    logic [dscl_pkg::CNT_W-1:0] n_cols;
    logic [dscl_pkg::COLS_FIELD_W-1:0] cfg_cols_raw;
    logic                       cols_write;

    // Input side position tracking.
    logic [dscl_pkg::COL_W-1:0] r_col;
    logic [dscl_pkg::COL_W-1:0] n_col;
    logic [dscl_pkg::CNT_W-1:0] col_inc;
    logic                       col_wrap;
    logic                       r_row_done;
    logic                       in_acc;
    dscl_pkg::t_cell            in_cell;

    // Window stage registers.
    logic                       r_b_valid;
    dscl_pkg::t_cell            r_b_cell;
    logic [dscl_pkg::COL_W-1:0] r_b_col;
    logic                       r_b_l1ok;
    logic                       r_b_byp;
    dscl_pkg::t_word            r_byp_word;
    dscl_pkg::t_word            ram_rdata;
    dscl_pkg::t_word            b_word;
    dscl_pkg::t_word            b_wdata;
    dscl_pkg::t_cell            l1_cell;
    logic                       l2_nz;

    // Window taps: row0 is the newest row, row2 the oldest.
    logic                       r_r0_1;
    logic                       r_r0_2;
    dscl_pkg::t_cell            r_r1_1;
    logic                       r_r1_2;
    logic                       r_r2_1;
    logic                       r_r2_2;
    dscl_pkg::t_window          win;
    logic                       hit;

    // Label counter and result queue.
    logic [dscl_pkg::LABEL_W-1:0] r_label_cnt;
    logic                         push;
    logic                         lab_take;
    logic                         pop;
    dscl_pkg::t_out               res;
    dscl_pkg::t_out               r_q [Q_DEPTH];
    logic [1:0]                   r_q_head;
    logic [1:0]                   r_q_tail;
    logic [1:0]                   r_q_count;
    logic [2:0]                   q_need;

    // ---------------------------------------------------------------
    // Configuration: the row width is clamped into the legal range.
    // ---------------------------------------------------------------
    assign cfg_cols_raw = i_cfg_data[dscl_pkg::COLS_FIELD_W-1:0];
    assign cols_write   = i_cfg_we && (i_cfg_idx == dscl_pkg::CFG_COLS);

    always_comb begin
        if (cfg_cols_raw == '0) begin
            n_cols = dscl_pkg::CNT_W'(1);
        end else if (32'(cfg_cols_raw) > 32'(dscl_pkg::MAX_COLS)) begin
            n_cols = dscl_pkg::CNT_W'(dscl_pkg::MAX_COLS);
        end else begin
            n_cols = dscl_pkg::CNT_W'(cfg_cols_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes_uw <= dscl_pkg::CODES_UW_RST;
            r_codes_el <= dscl_pkg::CODES_EL_RST;
            r_cols     <= dscl_pkg::COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dscl_pkg::CFG_CODES_UW: r_codes_uw <= i_cfg_data;
                dscl_pkg::CFG_CODES_EL: r_codes_el <= i_cfg_data;
                dscl_pkg::CFG_COLS:     r_cols     <= n_cols;
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input acceptance. The queue must have room for every word that
    // may still arrive from the window stage.
    // ---------------------------------------------------------------
    assign q_need  = {1'b0, r_q_count} + {2'b00, r_b_valid};
    assign o_stall = !i_rst_n || (q_need >= 3'(Q_DEPTH));
    assign in_acc  = i_valid && !o_stall;

    assign in_cell.raster = !i_data.op;
    assign in_cell.s_pres = !i_data.op && i_data.stream_present;
    assign in_cell.s_nz   = !i_data.op && i_data.stream_present && (i_data.stream_id != '0);
    assign in_cell.d_pres = !i_data.op && i_data.dir_present;
    assign in_cell.d_code = i_data.dir_code;

    assign col_inc  = dscl_pkg::CNT_W'(r_col) + dscl_pkg::CNT_W'(1);
    assign col_wrap = (col_inc >= r_cols);
    assign n_col    = col_wrap ? '0 : col_inc[dscl_pkg::COL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cols_write) begin
            r_col      <= '0;
            r_row_done <= 1'b0;
        end else if (in_acc) begin
            r_col <= n_col;
            if (col_wrap) begin
                r_row_done <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Line memory: each column keeps the cell one row up and the nonzero
    // bit two rows up; read at the accept clock, written in the window stage.
    // ---------------------------------------------------------------
    dscl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (dscl_pkg::MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_col),
        .i_wdata (b_wdata),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_byp   <= 1'b0;
        end else begin
            r_b_valid <= in_acc;
            // With one column per row, the column just read is the one
            // being written this clock, so the write data is forwarded.
            r_b_byp   <= in_acc && r_b_valid && (r_b_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_cell   <= in_cell;
            r_b_col    <= r_col;
            r_b_l1ok   <= r_row_done;
            r_byp_word <= b_wdata;
        end
    end

    // Until a full row has gone by, the memory words are stale.
    assign b_word  = r_b_byp ? r_byp_word : ram_rdata;
    assign l1_cell = r_b_l1ok ? b_word.row1 : '0;
    assign l2_nz   = r_b_l1ok && b_word.row2_nz;

    assign b_wdata.row1    = r_b_cell;
    assign b_wdata.row2_nz = l1_cell.s_nz;

    // ---------------------------------------------------------------
    // Window taps, shifted once per word.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cols_write) begin
            r_r0_1 <= 1'b0;
            r_r0_2 <= 1'b0;
            r_r1_1 <= '0;
            r_r1_2 <= 1'b0;
            r_r2_1 <= 1'b0;
            r_r2_2 <= 1'b0;
        end else if (r_b_valid) begin
            r_r0_1 <= r_b_cell.s_nz;
            r_r0_2 <= r_r0_1;
            r_r1_1 <= l1_cell;
            r_r1_2 <= r_r1_1.s_nz;
            r_r2_1 <= l2_nz;
            r_r2_2 <= r_r2_1;
        end
    end

    // The center column is one behind the newest one.
    always_comb begin
        win.self_cell = r_r1_1;
        win.nb_nz     = {r_b_cell.s_nz, r_r0_1, r_r0_2, l1_cell.s_nz,
                         r_r1_2, l2_nz, r_r2_1, r_r2_2};
        win.at_left   = (r_cols == dscl_pkg::CNT_W'(1)) ||
                        (r_b_col == dscl_pkg::COL_W'(1));
        win.at_right  = (r_b_col == '0);
    end

    dscl_lookup u_lookup (
        .i_codes_uw (r_codes_uw),
        .i_codes_el (r_codes_el),
        .i_win      (win),
        .o_hit      (hit)
    );

    // ---------------------------------------------------------------
    // Label counter, saturating at its maximum.
    // ---------------------------------------------------------------
    assign push     = r_b_valid && r_r1_1.raster;
    assign lab_take = push && hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_cnt <= dscl_pkg::LABEL_RST;
        end else if (lab_take && (r_label_cnt != dscl_pkg::LABEL_MAX)) begin
            r_label_cnt <= r_label_cnt + dscl_pkg::LABEL_W'(1);
        end
    end

    assign res.label         = hit ? r_label_cnt : '0;
    assign res.label_present = hit;

    // ---------------------------------------------------------------
    // Result queue.
    // ---------------------------------------------------------------
    assign o_valid = (r_q_count != '0);
    assign o_data  = r_q[r_q_head];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_head  <= '0;
            r_q_tail  <= '0;
            r_q_count <= '0;
        end else begin
            if (push) begin
                r_q_tail <= (r_q_tail == 2'(Q_DEPTH - 1)) ? '0 : r_q_tail + 2'd1;
            end
            if (pop) begin
                r_q_head <= (r_q_head == 2'(Q_DEPTH - 1)) ? '0 : r_q_head + 2'd1;
            end
            r_q_count <= r_q_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_q_tail] <= res;
        end
    end

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    `DSCL_ASSERT_ALWAYS(a_label_cnt_nonzero, i_clk, i_rst_n, r_label_cnt != '0,
        "label counter reached zero")
    `DSCL_ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, r_q_count <= 2'(Q_DEPTH),
        "result queue overflow")
    `DSCL_ASSERT_NEXT(a_accept_to_window, i_clk, i_rst_n, in_acc, r_b_valid,
        "accepted word did not reach the window stage")
    `DSCL_ASSERT_NEXT(a_label_step, i_clk, i_rst_n,
        lab_take && (r_label_cnt != dscl_pkg::LABEL_MAX),
        r_label_cnt == $past(r_label_cnt) + 31'd1, "label counter did not advance")
    `DSCL_ASSERT_ALWAYS(a_bypass_single_col, i_clk, i_rst_n,
        !(r_b_valid && r_b_byp) || (r_cols == dscl_pkg::CNT_W'(1)),
        "line memory forwarding used with more than one column")

endmodule

@@ hw/rtl/dscl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module dscl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dscl_lookup.sv @@
// Direction code match and neighbor check for the cell at the window center.
module dscl_lookup (
    input  logic [dscl_pkg::CFG_W-1:0] i_codes_uw,
    input  logic [dscl_pkg::CFG_W-1:0] i_codes_el,
    input  dscl_pkg::t_window          i_win,
    output logic                       o_hit
);

    logic [63:0] codes_all;
    logic [7:0]  match;
    logic [7:0]  first;
    logic        blocked;

    assign codes_all = {i_codes_el, i_codes_uw};

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            match[k] = (codes_all[8*k +: 8] == i_win.self_cell.d_code);
        end
    end

    // The first matching neighbor in order wins: isolate the lowest set bit.
    assign first = match & (~match + 8'd1);

    assign blocked = ((|(first & dscl_pkg::LEFT_SIDE)) && i_win.at_left) ||
                     ((|(first & dscl_pkg::RIGHT_SIDE)) && i_win.at_right);

    assign o_hit = i_win.self_cell.raster && i_win.self_cell.d_pres &&
                   !i_win.self_cell.s_pres && (|(first & i_win.nb_nz)) && !blocked;

endmodule

@@ tb/tb_downstream_stream_cell_labeler.sv @@
// Self-checking testbench for the downstream stream cell labeler: directed and random rasters.
module tb_downstream_stream_cell_labeler;

    import dscl_pkg::*;

    // Operation codes of an input word.
    localparam logic OP_RASTER = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Neighbor order of the direction code registers.
    typedef enum int unsigned {
        NB_NW = 0, NB_N = 1, NB_NE = 2, NB_W = 3, NB_E = 4, NB_SW = 5, NB_S = 6, NB_SE = 7
    } neighbor_t;

    // Neighbors that lie one column left or one column right of the center cell.
    localparam logic [7:0] LEFT_NB  = (8'd1 << NB_NW) | (8'd1 << NB_W) | (8'd1 << NB_SW);
    localparam logic [7:0] RIGHT_NB = (8'd1 << NB_NE) | (8'd1 << NB_E) | (8'd1 << NB_SE);

    typedef enum int unsigned {
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
    } idle_mode_t;

    localparam int SRING_DEPTH = 2 * MAX_COLS + 4;
    localparam int DRING_DEPTH = MAX_COLS + 2;
    localparam logic [LABEL_W-1:0] LABEL_LIMIT = '1;

    // Cycles allowed after the last expected word before the block counts as quiet.
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct packed {
        logic [31:0] id;
        logic        present;
        logic        raster;
    } stream_slot_t;

    typedef struct packed {
        logic [7:0] code;
        logic       present;
    } dir_slot_t;

    // A word waiting to be sent; a hold word is not sent before every result is out.
    typedef struct {
        t_in word;
        bit  hold;
    } pending_word_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_in                  i_data = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_out                 o_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    downstream_stream_cell_labeler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial forever #4 i_clk = ~i_clk;

    pending_word_t pending_words[$];
    t_out          expected_labels[$];
    idle_mode_t    idle_mode = IDLE_NONE;
    // Set by the monitor at each edge, so other blocks read a settled value.
    bit            results_drained = 1'b1;
    int            mismatch_count = 0;
    int unsigned   cycle_count = 0;

    // Predicted state of the block: both line rings, the label counter and the registers.
    stream_slot_t             stream_ring [SRING_DEPTH];
    dir_slot_t                dir_ring [DRING_DEPTH];
    logic [LABEL_W-1:0]       next_label;
    int unsigned              col_pos;
    int unsigned              s_head;
    int unsigned              d_head;
    int unsigned              row_width;
    logic [31:0]              codes_uw;
    logic [31:0]              codes_el;

    function automatic int unsigned ring_back(int unsigned head, int unsigned back,
                                              int unsigned size);
        return (head + size - (back % size)) % size;
    endfunction

    function automatic logic [7:0] code_of(int unsigned k);
        return (k < 4) ? codes_uw[8*k +: 8] : codes_el[8*(k-4) +: 8];
    endfunction

    // Empty rings and a restarted raster; the label counter is left alone.
    task automatic clear_rings();
        for (int i = 0; i < SRING_DEPTH; i++) stream_ring[i] = '0;
        for (int i = 0; i < DRING_DEPTH; i++) dir_ring[i] = '0;
        col_pos = 0;
        s_head  = 0;
        d_head  = 0;
    endtask

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        int unsigned cols;
        case (idx)
            CFG_CODES_UW: codes_uw = value;
            CFG_CODES_EL: codes_el = value;
            CFG_COLS: begin
                cols = value[COLS_FIELD_W-1:0];
                if (cols == 0) cols = 1;
                if (cols > MAX_COLS) cols = MAX_COLS;
                row_width = cols;
                clear_rings();
            end
            default: ;
        endcase
    endtask

    // Stores one accepted word and labels the cell one row and one column back.
    // The lagged cell yields a result word only if it was a raster cell.
    task automatic label_lagged_cell(input t_in w, output bit has_result, output t_out result);
        bit           is_raster;
        bit           in_raster;
        int unsigned  dcol;
        int unsigned  k;
        int unsigned  back_of [8];
        stream_slot_t center;
        stream_slot_t nb;
        dir_slot_t    center_dir;
        is_raster = (w.op == OP_RASTER);
        dcol = (col_pos == 0) ? row_width - 1 : col_pos - 1;
        stream_ring[s_head] = '{id: w.stream_id, present: is_raster && w.stream_present,
                                raster: is_raster};
        dir_ring[d_head] = '{code: w.dir_code, present: is_raster && w.dir_present};
        center     = stream_ring[ring_back(s_head, row_width + 1, SRING_DEPTH)];
        center_dir = dir_ring[ring_back(d_head, row_width + 1, DRING_DEPTH)];
        // Distance of each neighbor behind the newest word, in neighbor order.
        back_of = '{2*row_width + 2, 2*row_width + 1, 2*row_width, row_width + 2,
                    row_width, 2, 1, 0};
        result = '0;
        has_result = center.raster;
        if (center.raster && center_dir.present && !center.present) begin
            // The first neighbor in order whose code matches wins.
            k = 8;
            for (int i = 7; i >= 0; i--) begin
                if (code_of(i) == center_dir.code) k = i;
            end
            if (k < 8) begin
                in_raster = !((LEFT_NB[k] && dcol == 0) ||
                              (RIGHT_NB[k] && dcol + 1 >= row_width));
                if (in_raster) begin
                    nb = stream_ring[ring_back(s_head, back_of[k], SRING_DEPTH)];
                    if (nb.present && nb.id != 0) begin
                        result.label = next_label;
                        result.label_present = 1'b1;
                        if (next_label != LABEL_LIMIT) next_label++;
                    end
                end
            end
        end
        s_head  = (s_head + 1) % SRING_DEPTH;
        d_head  = (d_head + 1) % DRING_DEPTH;
        col_pos = (col_pos + 1 >= row_width) ? 0 : col_pos + 1;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic int unsigned sender_idle_pct();
        return (idle_mode == IDLE_SENDER) ? 48 : (idle_mode == IDLE_BOTH) ? 13 : 0;
    endfunction

    function automatic int unsigned receiver_stall_pct();
        return (idle_mode == IDLE_RECEIVER) ? 48 : (idle_mode == IDLE_BOTH) ? 13 : 0;
    endfunction

    function automatic t_in make_word(logic op, logic [7:0] code, logic dir_p,
                                      logic [31:0] id, logic str_p);
        t_in w;
        w.op             = op;
        w.dir_code       = code;
        w.dir_present    = dir_p;
        w.stream_id      = id;
        w.stream_present = str_p;
        return w;
    endfunction

    // Mostly stream cells and direction cells aimed at one of the current codes,
    // with some missing cells and a little noise, flush words among it.
    function automatic t_in random_raster_word();
        int unsigned pick;
        logic [31:0] id;
        logic [7:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            id = (pick < 4) ? 32'h0 : (pick < 7) ? 32'h8000_0000 :
                 (pick < 10) ? 32'h7FFF_FFFF : $urandom;
            return make_word(OP_RASTER, $urandom, $urandom_range(0, 1), id, 1'b1);
        end else if (pick < 82) begin
            code = ($urandom_range(0, 99) < 85) ? code_of($urandom_range(0, 7)) : $urandom;
            return make_word(OP_RASTER, code, 1'b1, $urandom, 1'b0);
        end else if (pick < 94) begin
            return make_word(OP_RASTER, $urandom, 1'b0, $urandom, 1'b0);
        end
        return make_word($urandom_range(0, 1), $urandom, $urandom_range(0, 1), $urandom,
                         $urandom_range(0, 1));
    endfunction

    function automatic logic [31:0] clustered_codes();
        return {6'd0, 2'($urandom_range(0, 3)), 6'd0, 2'($urandom_range(0, 3)),
                6'd0, 2'($urandom_range(0, 3)), 6'd0, 2'($urandom_range(0, 3))};
    endfunction

    task automatic push_word(input t_in w);
        pending_words.push_back('{word: w, hold: 1'b0});
    endtask

    task automatic queue_raster(input int unsigned count);
        repeat (count) push_word(random_raster_word());
    endtask

    // Flush words carry random payload, which the block must ignore.
    task automatic queue_flush(input int unsigned count);
        repeat (count) begin
            push_word(make_word(OP_FLUSH, $urandom, $urandom_range(0, 1), $urandom,
                                $urandom_range(0, 1)));
        end
    endtask

    // Waits for an empty send queue, no word on the input and no result outstanding,
    // then lets the pipeline settle. Sampled at the falling edge to stay clear of
    // the updates made at the rising edge.
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid || !results_drained);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        wait_until_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        apply_register(idx, value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Driver: a word stays on the input until accepted; a new one is taken from the
    // queue only when the input is empty or the current word has just been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct() &&
                !(pending_words[0].hold && (i_valid || !results_drained))) begin
                i_data  <= pending_words[0].word;
                i_valid <= 1'b1;
                pending_words.delete(0);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result word against the oldest expectation, then feeds
    // the word accepted at this edge to the predictor. Checking comes first, so a
    // result can never be matched against an expectation made at the same edge.
    always @(posedge i_clk) begin : monitor_blk
        bit   has_label;
        t_out want;
        if (!i_rst_n) begin
            i_stall         <= 1'b0;
            results_drained <= 1'b1;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_labels.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected: label %0d present %0b",
                                              o_data.label, o_data.label_present));
                end else begin
                    want = expected_labels.pop_front();
                    if (o_data.label !== want.label)
                        report_mismatch($sformatf("label %0d, expected %0d",
                                                  o_data.label, want.label));
                    if (o_data.label_present !== want.label_present)
                        report_mismatch($sformatf("label_present %0b, expected %0b",
                                                  o_data.label_present, want.label_present));
                end
            end
            if (i_valid && !o_stall) begin
                label_lagged_cell(i_data, has_label, want);
                if (has_label) expected_labels.push_back(want);
            end
            results_drained <= (expected_labels.size() == 0);
            i_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
        end
    end

    // Timeout: a stuck handshake or a lost result ends the run here.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("downstream_stream_cell_labeler test failed");
        $finish;
    end

    initial begin : stimulus_blk
        int unsigned phase_widths [12];
        logic [31:0] uw;
        logic [31:0] el;
        logic [31:0] cols_word;
        int unsigned rows;
        phase_widths = '{1, 2, 0, 5, 3, 8, 4, 7, 2, 6, 3, 1};

        // Predictor state after reset.
        clear_rings();
        next_label = LABEL_RST;
        codes_uw   = CODES_UW_RST;
        codes_el   = CODES_EL_RST;
        row_width  = MAX_COLS;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed raster, three columns and four rows, with the default codes.
        // Row 0 holds stream cells at the id extremes, including a present zero id.
        // Row 1 aims off the left edge, at the top row, and off the right edge.
        // Row 2 aims at a cell whose id is not present and east at a stream cell.
        // Row 3 has a code that matches nothing, a hit on the row above, and a
        // look south into the flush row.
        write_register(CFG_COLS, 32'd3);
        @(negedge i_clk);
        push_word(make_word(OP_RASTER, code_of(NB_N), 1'b1, 32'h7FFF_FFFF, 1'b1));
        push_word(make_word(OP_RASTER, code_of(NB_N), 1'b1, 32'h8000_0000, 1'b1));
        push_word(make_word(OP_RASTER, code_of(NB_N), 1'b1, 32'h0000_0000, 1'b1));
        push_word(make_word(OP_RASTER, code_of(NB_NW), 1'b1, 32'h0000_1234, 1'b0));
        push_word(make_word(OP_RASTER, code_of(NB_N), 1'b1, 32'hFFFF_FFFF, 1'b0));
        push_word(make_word(OP_RASTER, code_of(NB_NE), 1'b1, 32'h0000_0001, 1'b0));
        push_word(make_word(OP_RASTER, code_of(NB_N), 1'b1, 32'h0000_0000, 1'b0));
        push_word(make_word(OP_RASTER, code_of(NB_E), 1'b1, 32'h5555_5555, 1'b0));
        push_word(make_word(OP_RASTER, 8'hFF, 1'b0, 32'h8000_0001, 1'b1));
        push_word(make_word(OP_RASTER, 8'h00, 1'b1, 32'hAAAA_AAAA, 1'b0));
        push_word(make_word(OP_RASTER, code_of(NB_NE), 1'b1, 32'h0000_0000, 1'b0));
        push_word(make_word(OP_RASTER, code_of(NB_S), 1'b1, 32'h7FFF_FFFF, 1'b0));
        push_word(make_word(OP_FLUSH, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1));
        push_word(make_word(OP_FLUSH, 8'h00, 1'b0, 32'h0000_0000, 1'b0));
        queue_flush(2);

        // Random phases: each picks a code setting, a row width and an idle mode.
        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin
                    uw = $urandom;
                    el = $urandom;
                end
                1: begin
                    uw = CODES_UW_RST;
                    el = CODES_EL_RST;
                end
                2: begin
                    // All-zero and all-one code bytes: several codes, or every code, match at once.
                    uw = (p == 6) ? '1 : '0;
                    el = (p == 2) ? '0 : '1;
                end
                default: begin
                    // Few distinct code values, so several neighbors match.
                    uw = clustered_codes();
                    el = clustered_codes();
                end
            endcase
            write_register(CFG_CODES_UW, uw);
            write_register(CFG_CODES_EL, el);
            cols_word = phase_widths[p];
            if (p % 2 == 1) cols_word[31:COLS_FIELD_W] = $urandom;
            write_register(CFG_COLS, cols_word);
            @(negedge i_clk);
            idle_mode = idle_mode_t'(p % 4);
            rows = 40 / row_width + 2;
            if (p % 4 == 1) begin
                // Change the codes halfway through a raster while the input rests.
                queue_raster(rows * row_width / 2);
                write_register(CFG_CODES_UW, $urandom);
                @(negedge i_clk);
                queue_raster(rows * row_width - rows * row_width / 2);
            end else begin
                queue_raster(rows * row_width);
            end
            queue_flush(row_width + 1);
            if (p % 2 == 1) begin
                // A second raster continues right after the flush words; some
                // phases leave it unflushed, so the next width write cuts it off.
                queue_raster(rows * row_width);
                if (p % 3 != 2) queue_flush(row_width + 1);
            end
            if (p == 3 || p == 8) pending_words[pending_words.size() / 2].hold = 1'b1;
        end

        // A width above the maximum acts as the maximum; these cells are cut off
        // by the next width write before any of them gets a result.
        write_register(CFG_COLS, 32'd2047);
        @(negedge i_clk);
        idle_mode = IDLE_SENDER;
        queue_raster(40);
        queue_flush(50);

        // Full-width raster: a partial first row, pushed out by a full flush row.
        write_register(CFG_CODES_UW, CODES_UW_RST);
        write_register(CFG_CODES_EL, CODES_EL_RST);
        write_register(CFG_COLS, 32'd1024);
        @(negedge i_clk);
        idle_mode = IDLE_BOTH;
        queue_raster(200);
        queue_flush(row_width + 1);
        pending_words[pending_words.size() / 2].hold = 1'b1;

        wait_until_drained();
        if (mismatch_count == 0) begin
            $display("downstream_stream_cell_labeler test passed");
        end else begin
            $display("downstream_stream_cell_labeler test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dscl_pkg.sv
hw/rtl/dscl_ram.sv
hw/rtl/dscl_lookup.sv
hw/rtl/downstream_stream_cell_labeler.sv
tb/tb_downstream_stream_cell_labeler.sv
